>>> rtl/rvx_pkg.sv
// shared constants and types for the rv64i execute block
package rvx_pkg;

	localparam int MEM_BYTES = 131072;
	localparam int ADDR_W    = $clog2(MEM_BYTES);
	localparam int LANES     = 8;
	localparam int LANE_W    = $clog2(LANES);
	localparam int ROWS      = MEM_BYTES / LANES;
	localparam int ROW_W     = $clog2(ROWS);

	localparam logic [6:0] OP_R      = 7'b0110011;
	localparam logic [6:0] OP_I      = 7'b0010011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;

	localparam logic REQ_EXEC    = 1'b0;
	localparam logic REQ_PRELOAD = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [31:0]       instr;
		logic [ADDR_W-1:0] load_addr;
		logic [7:0]        load_byte;
	} in_t;

	typedef struct packed {
		logic [31:0]        next_pc;
		logic               reg_written;
		logic [4:0]         reg_index;
		logic signed [63:0] reg_value;
		logic               store_done;
		logic [ADDR_W-1:0]  store_addr;
	} out_t;

	// per-lane write request into the byte memory
	typedef struct packed {
		logic [LANES-1:0]            we;
		logic [LANES-1:0][ROW_W-1:0] row;
		logic [LANES-1:0][7:0]       data;
	} lane_wr_t;

endpackage

>>> rtl/rvx_if.sv
// valid/ready channel interfaces for the item and result transactions
interface rvx_in_if;
	import rvx_pkg::*;
	logic valid;
	logic ready;
	in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rvx_out_if;
	import rvx_pkg::*;
	logic valid;
	logic ready;
	out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rvx_regfile.sv
// 32 x 64 register file, two synchronous read ports, valid bits for reset
module rvx_regfile (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [1:0][4:0]  rd_addr,
	output logic [1:0][63:0] rd_data,
	input  logic             we,
	input  logic [4:0]       wr_addr,
	input  logic [63:0]      wr_data
);
	logic [63:0] mem [32];
	logic [31:0] vld_q;

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// storage write and registered reads (old data on same-entry write)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			for (int j = 0; j < 2; j++) begin
				rd_data[j] <= vld_q[rd_addr[j]] ? mem[rd_addr[j]] : 64'd0;
			end
		end
	end
endmodule

>>> rtl/rvx_dmem.sv
// byte-lane data memory with a clearing sweep after reset
module rvx_dmem (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rd_en,
	input  logic [rvx_pkg::LANES-1:0][rvx_pkg::ROW_W-1:0] rd_row,
	output logic [rvx_pkg::LANES-1:0][7:0]         rd_data,
	input  rvx_pkg::lane_wr_t                      wr,
	output logic                                   busy
);
	import rvx_pkg::*;

	logic             busy_q;
	logic [ROW_W-1:0] clr_q;

	assign busy = busy_q;

	// clearing sweep, one row of all lanes per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ROW_W'(ROWS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [7:0] mem [ROWS];
		logic [7:0] rd_q;
		// one write and one registered read per lane
		always_ff @(posedge clk) begin
			if (busy_q) begin
				mem[clr_q] <= 8'd0;
			end else if (wr.we[i]) begin
				mem[wr.row[i]] <= wr.data[i];
			end
			if (rd_en) begin
				rd_q <= mem[rd_row[i]];
			end
		end
		assign rd_data[i] = rd_q;
	end
endmodule

>>> rtl/rv64i_instruction_execute.sv
// rv64i execute top level: decode/execute stage, memory stage, result register
//
//  channel | dir | transaction
//  in_ch   | in  | instruction word to execute or byte to preload
//  out_ch  | out | next pc, register write and store report
//
// one item per cycle sustained unless the result stalls or the memory clear runs
// stages: s1 executes with operands from the register file, s2 takes load data
// from the byte lanes and commits, then the result register
// after reset the byte memory is swept to zero with ready low
// a stalled result freezes all stages; forwarding covers register and memory reuse
module rv64i_instruction_execute (
	input logic       clk,
	input logic       arst_n,
	rvx_in_if.sink    in_ch,
	rvx_out_if.source out_ch
);
	import rvx_pkg::*;

	logic adv, busy, acc;

	// stage 1 registers
	logic            v_s1;
	in_t             it_s1;
	logic [1:0]      cap_v_s1;
	logic [1:0][63:0] cap_d_s1;
	logic [31:0]     pc_q;

	// stage 2 registers
	logic              v_s2, wr_s2, ld_s2, st_s2;
	logic [4:0]        rd_s2;
	logic [63:0]       val_s2;
	logic [2:0]        f3_s2, alo_s2;
	logic [31:0]       npc_s2;
	logic [ADDR_W-1:0] saddr_s2;
	lane_wr_t          lw_s2;
	logic [LANES-1:0]      byp_v_s2;
	logic [LANES-1:0][7:0] byp_d_s2;

	// result register
	logic out_v_q;
	out_t out_q;

	logic [1:0][63:0] rf_q;
	logic [LANES-1:0][7:0] ram_q;
	logic [63:0] fin_s2;
	logic        cm_rf_we;
	lane_wr_t    cm_lw;

	assign adv   = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv && !busy;
	assign acc   = in_ch.valid && in_ch.ready;

	// register file reads for the item entering s1
	logic [1:0][4:0] rs_in;
	assign rs_in[0] = in_ch.data.instr[19:15];
	assign rs_in[1] = in_ch.data.instr[24:20];
	assign cm_rf_we = adv && v_s2 && wr_s2;

	rvx_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .rd_en(adv), .rd_addr(rs_in), .rd_data(rf_q),
		.we(cm_rf_we), .wr_addr(rd_s2), .wr_data(fin_s2)
	);

	// s1 operand forwarding
	logic [63:0] a, b;
	always_comb begin
		if (v_s2 && wr_s2 && rd_s2 == it_s1.instr[19:15]) a = fin_s2;
		else if (cap_v_s1[0]) a = cap_d_s1[0];
		else a = rf_q[0];
		if (v_s2 && wr_s2 && rd_s2 == it_s1.instr[24:20]) b = fin_s2;
		else if (cap_v_s1[1]) b = cap_d_s1[1];
		else b = rf_q[1];
	end

	// s1 execute
	logic        ex_wr, ex_ld, ex_st;
	logic [63:0] ex_val;
	logic [31:0] ex_npc;
	logic [ADDR_W-1:0] ex_ad;
	lane_wr_t    ex_lw;
	logic [LANES-1:0][ROW_W-1:0] ex_rrow;
	always_comb begin
		logic [31:0] ins;
		logic [6:0]  op;
		logic [2:0]  f3, off;
		logic [6:0]  f7;
		logic [63:0] immi, imms, immb, immj, immu, sum;
		logic [5:0]  sh;
		logic        take, lts, ltu;
		logic [3:0]  nb;
		ins  = it_s1.instr;
		op   = ins[6:0];
		f3   = ins[14:12];
		f7   = ins[31:25];
		immi = {{52{ins[31]}}, ins[31:20]};
		imms = {{52{ins[31]}}, ins[31:25], ins[11:7]};
		immb = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
		immj = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
		immu = {{32{ins[31]}}, ins[31:12], 12'd0};
		sh   = (op == OP_R) ? b[5:0] : ins[25:20];
		lts  = $signed(a) < $signed((op == OP_I) ? immi : b);
		ltu  = a < ((op == OP_I) ? immi : b);
		sum  = a + ((op == OP_STORE) ? imms : immi);
		take = 1'b0;
		ex_wr  = 1'b0;
		ex_ld  = 1'b0;
		ex_st  = 1'b0;
		ex_val = '0;
		ex_npc = pc_q + 32'd4;
		unique case (op)
			OP_R: begin
				ex_wr = 1'b1;
				if (f7 == 7'h00) begin
					unique case (f3)
						3'd0: ex_val = a + b;
						3'd1: ex_val = a << sh;
						3'd2: ex_val = {63'd0, lts};
						3'd3: ex_val = {63'd0, ltu};
						3'd4: ex_val = a ^ b;
						3'd5: ex_val = a >> sh;
						3'd6: ex_val = a | b;
						default: ex_val = a & b;
					endcase
				end else if (f7 == 7'h20 && f3 == 3'd0) begin
					ex_val = a - b;
				end else if (f7 == 7'h20 && f3 == 3'd5) begin
					ex_val = 64'($signed(a) >>> sh);
				end else begin
					ex_wr = 1'b0;
				end
			end
			OP_I: begin
				ex_wr = 1'b1;
				unique case (f3)
					3'd0: ex_val = sum;
					3'd1: if (ins[31:26] == 6'd0) ex_val = a << sh; else ex_wr = 1'b0;
					3'd2: ex_val = {63'd0, lts};
					3'd3: ex_val = {63'd0, ltu};
					3'd4: ex_val = a ^ immi;
					3'd5: begin
						if (ins[31:26] == 6'd0) ex_val = a >> sh;
						else if (ins[31:26] == 6'h10) ex_val = 64'($signed(a) >>> sh);
						else ex_wr = 1'b0;
					end
					3'd6: ex_val = a | immi;
					default: ex_val = a & immi;
				endcase
			end
			OP_LOAD: begin
				ex_ld = (f3 != 3'd7);
				ex_wr = ex_ld;
			end
			OP_STORE: ex_st = !f3[2];
			OP_BRANCH: begin
				unique case (f3)
					3'd0: take = (a == b);
					3'd1: take = (a != b);
					3'd4: take = lts;
					3'd5: take = !lts;
					3'd6: take = ltu;
					3'd7: take = !ltu;
					default: take = 1'b0;
				endcase
				if (take) ex_npc = pc_q + immb[31:0];
			end
			OP_LUI: begin
				ex_wr  = 1'b1;
				ex_val = immu;
			end
			OP_AUIPC: begin
				ex_wr  = 1'b1;
				ex_val = {32'd0, pc_q} + immu;
			end
			OP_JAL: begin
				ex_wr  = 1'b1;
				ex_val = {32'd0, pc_q} + 64'd4;
				ex_npc = pc_q + immj[31:0];
			end
			OP_JALR: begin
				if (f3 == 3'd0) begin
					ex_wr  = 1'b1;
					ex_val = {32'd0, pc_q} + 64'd4;
					ex_npc = {sum[31:1], 1'b0};
				end
			end
			default: ;
		endcase
		if (ins[11:7] == 5'd0) ex_wr = 1'b0;
		ex_ad = sum[ADDR_W-1:0];
		nb    = 4'd1 << f3[1:0];
		// lane addressing for loads and stores, one byte per lane
		for (int i = 0; i < LANES; i++) begin
			off = LANE_W'(i) - ex_ad[LANE_W-1:0];
			ex_rrow[i] = ex_ad[ADDR_W-1:LANE_W]
				+ ROW_W'(LANE_W'(i) < ex_ad[LANE_W-1:0]);
			ex_lw.row[i]  = ex_rrow[i];
			ex_lw.we[i]   = ex_st && ({1'b0, off} < nb);
			ex_lw.data[i] = b[8*off +: 8];
		end
		// preload writes a single lane
		if (it_s1.req_type == REQ_PRELOAD) begin
			ex_wr = 1'b0;
			ex_ld = 1'b0;
			ex_st = 1'b0;
			ex_npc = pc_q;
			for (int i = 0; i < LANES; i++) begin
				ex_lw.we[i]   = (it_s1.load_addr[LANE_W-1:0] == LANE_W'(i));
				ex_lw.row[i]  = it_s1.load_addr[ADDR_W-1:LANE_W];
				ex_lw.data[i] = it_s1.load_byte;
			end
		end
		if (!v_s1) ex_lw.we = '0;
	end

	// memory commit from s2
	always_comb begin
		cm_lw = lw_s2;
		cm_lw.we = (adv && v_s2) ? lw_s2.we : '0;
	end

	rvx_dmem u_dmem (
		.clk(clk), .arst_n(arst_n), .rd_en(adv), .rd_row(ex_rrow), .rd_data(ram_q),
		.wr(cm_lw), .busy(busy)
	);

	// s2 load data assembly
	always_comb begin
		logic [LANES-1:0][7:0] lb;
		logic [63:0] raw;
		for (int i = 0; i < LANES; i++) begin
			lb[i] = byp_v_s2[i] ? byp_d_s2[i] : ram_q[i];
		end
		for (int k = 0; k < LANES; k++) begin
			raw[8*k +: 8] = lb[LANE_W'(alo_s2 + LANE_W'(k))];
		end
		unique case (f3_s2)
			3'd0: raw = {{56{raw[7]}}, raw[7:0]};
			3'd1: raw = {{48{raw[15]}}, raw[15:0]};
			3'd2: raw = {{32{raw[31]}}, raw[31:0]};
			3'd4: raw = {56'd0, raw[7:0]};
			3'd5: raw = {48'd0, raw[15:0]};
			3'd6: raw = {32'd0, raw[31:0]};
			default: ;
		endcase
		fin_s2 = ld_s2 ? raw : val_s2;
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			pc_q    <= '0;
		end else if (adv) begin
			v_s1    <= acc;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
			if (v_s1) pc_q <= ex_npc;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= in_ch.data;
			for (int j = 0; j < 2; j++) begin
				cap_v_s1[j] <= cm_rf_we && (rd_s2 == rs_in[j]);
				cap_d_s1[j] <= fin_s2;
			end
			wr_s2    <= ex_wr;
			ld_s2    <= ex_ld;
			st_s2    <= ex_st;
			rd_s2    <= it_s1.instr[11:7];
			val_s2   <= ex_val;
			f3_s2    <= it_s1.instr[14:12];
			alo_s2   <= ex_ad[LANE_W-1:0];
			npc_s2   <= ex_npc;
			saddr_s2 <= ex_ad;
			lw_s2    <= ex_lw;
			for (int i = 0; i < LANES; i++) begin
				byp_v_s2[i] <= cm_lw.we[i] && (lw_s2.row[i] == ex_rrow[i]);
				byp_d_s2[i] <= lw_s2.data[i];
			end
			out_q.next_pc     <= npc_s2;
			out_q.reg_written <= wr_s2;
			out_q.reg_index   <= wr_s2 ? rd_s2 : 5'd0;
			out_q.reg_value   <= wr_s2 ? fin_s2 : 64'd0;
			out_q.store_done  <= st_s2;
			out_q.store_addr  <= st_s2 ? saddr_s2 : '0;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

`ifndef SYNTHESIS
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(in_ch.valid && in_ch.ready))
		else $error("item accepted during memory clear");
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		cm_rf_we |-> rd_s2 != 5'd0)
		else $error("register x0 written");
	a_store_no_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && st_s2) |-> !wr_s2)
		else $error("store also writes a register");
	a_pipe_empty_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !v_s1 && !v_s2)
		else $error("pipeline active during memory clear");
`endif
endmodule

>>> tb/rv64i_instruction_execute_chk.sv
// checker: predicts each result from the accepted items and compares the result channel
`timescale 1ns / 100ps
module rv64i_instruction_execute_chk
	import rvx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rvx_in_if    in_ch,
	rvx_out_if   out_ch,
	output int   fails,
	output int   pending
);

	logic [63:0] regs [32];
	logic [31:0] pc;
	logic [7:0]  mem [MEM_BYTES];
	out_t        expected_results [$];

	function automatic logic [ADDR_W-1:0] wrap(input logic [63:0] a);
		return a[ADDR_W-1:0];
	endfunction

	// model of one item: updates registers, pc and memory, returns the result
	task automatic exec_item(input in_t it, output out_t r);
		logic [31:0] ins, npc;
		logic [6:0]  op, f7;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic [63:0] a, b, immi, imm, val, ad;
		logic [5:0]  sh, hi;
		logic        wr, st, take;
		logic [ADDR_W-1:0] saddr;
		int          n;
		ins  = it.instr;
		npc  = pc + 32'd4;
		op   = ins[6:0];
		rd   = ins[11:7];
		f3   = ins[14:12];
		f7   = ins[31:25];
		a    = regs[ins[19:15]];
		b    = regs[ins[24:20]];
		immi = {{52{ins[31]}}, ins[31:20]};
		val  = '0;
		wr   = 1'b0;
		st   = 1'b0;
		saddr = '0;
		r = '0;
		if (it.req_type == REQ_PRELOAD) begin
			mem[it.load_addr] = it.load_byte;
			r.next_pc = pc;
			return;
		end
		case (op)
			OP_R: begin
				sh = b[5:0];
				wr = 1'b1;
				if (f7 == 7'h00) begin
					case (f3)
						3'd0: val = a + b;
						3'd1: val = a << sh;
						3'd2: val = {63'd0, $signed(a) < $signed(b)};
						3'd3: val = {63'd0, a < b};
						3'd4: val = a ^ b;
						3'd5: val = a >> sh;
						3'd6: val = a | b;
						default: val = a & b;
					endcase
				end else if (f7 == 7'h20 && f3 == 3'd0) begin
					val = a - b;
				end else if (f7 == 7'h20 && f3 == 3'd5) begin
					val = $signed(a) >>> sh;
				end else begin
					wr = 1'b0;
				end
			end
			OP_I: begin
				sh = ins[25:20];
				hi = ins[31:26];
				wr = 1'b1;
				case (f3)
					3'd0: val = a + immi;
					3'd1: if (hi == 6'd0) val = a << sh; else wr = 1'b0;
					3'd2: val = {63'd0, $signed(a) < $signed(immi)};
					3'd3: val = {63'd0, a < immi};
					3'd4: val = a ^ immi;
					3'd5: begin
						if (hi == 6'd0) val = a >> sh;
						else if (hi == 6'h10) val = $signed(a) >>> sh;
						else wr = 1'b0;
					end
					3'd6: val = a | immi;
					default: val = a & immi;
				endcase
			end
			OP_LOAD: begin
				ad = a + immi;
				wr = (f3 != 3'd7);
				n = 1 << f3[1:0];
				for (int i = 0; i < 8; i++)
					if (i < n) val[8*i +: 8] = mem[wrap(ad + i)];
				if (!f3[2]) begin
					case (f3[1:0])
						2'd0: val = {{56{val[7]}}, val[7:0]};
						2'd1: val = {{48{val[15]}}, val[15:0]};
						2'd2: val = {{32{val[31]}}, val[31:0]};
						default: ;
					endcase
				end
				if (f3 == 3'd7) val = '0;
			end
			OP_STORE: begin
				if (!f3[2]) begin
					imm = {{52{ins[31]}}, ins[31:25], ins[11:7]};
					saddr = wrap(a + imm);
					n = 1 << f3[1:0];
					for (int i = 0; i < n; i++)
						mem[wrap({47'd0, saddr} + i)] = b[8*i +: 8];
					st = 1'b1;
				end
			end
			OP_BRANCH: begin
				imm = {{52{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
				case (f3)
					3'd0: take = (a == b);
					3'd1: take = (a != b);
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = !($signed(a) < $signed(b));
					3'd6: take = a < b;
					3'd7: take = a >= b;
					default: take = 1'b0;
				endcase
				if (take) npc = pc + imm[31:0];
			end
			OP_LUI: begin
				wr = 1'b1;
				val = {{32{ins[31]}}, ins[31:12], 12'd0};
			end
			OP_AUIPC: begin
				wr = 1'b1;
				val = {32'd0, pc} + {{32{ins[31]}}, ins[31:12], 12'd0};
			end
			OP_JAL: begin
				imm = {{44{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
				wr = 1'b1;
				val = {32'd0, pc} + 64'd4;
				npc = pc + imm[31:0];
			end
			OP_JALR: begin
				if (f3 == 3'd0) begin
					wr = 1'b1;
					val = {32'd0, pc} + 64'd4;
					ad = a + immi;
					npc = {ad[31:1], 1'b0};
				end
			end
			default: ;
		endcase
		if (rd == 5'd0) wr = 1'b0;
		if (wr) regs[rd] = val;
		pc = npc;
		r.next_pc     = npc;
		r.reg_written = wr;
		r.reg_index   = wr ? rd : 5'd0;
		r.reg_value   = wr ? val : 64'd0;
		r.store_done  = st;
		r.store_addr  = st ? saddr : '0;
	endtask

	// predict on accepted items, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		out_t e, got;
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) regs[i] = '0;
			for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
			pc = '0;
			fails <= 0;
			expected_results.delete();
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				exec_item(in_ch.data, e);
				expected_results.push_back(e);
			end
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction next_pc=%h", got.next_pc);
					fails <= fails + 1;
				end else begin
					e = expected_results.pop_front();
					if (got !== e) begin
						fails <= fails + 1;
						if (got.next_pc !== e.next_pc)
							$error("next_pc exp %h got %h", e.next_pc, got.next_pc);
						if (got.reg_written !== e.reg_written)
							$error("reg_written exp %b got %b", e.reg_written, got.reg_written);
						if (got.reg_index !== e.reg_index)
							$error("reg_index exp %0d got %0d", e.reg_index, got.reg_index);
						if (got.reg_value !== e.reg_value)
							$error("reg_value exp %h got %h", e.reg_value, got.reg_value);
						if (got.store_done !== e.store_done)
							$error("store_done exp %b got %b", e.store_done, got.store_done);
						if (got.store_addr !== e.store_addr)
							$error("store_addr exp %h got %h", e.store_addr, got.store_addr);
					end
				end
			end
		end
	end

	assign pending = expected_results.size();

endmodule

>>> tb/rv64i_instruction_execute_tb.sv
// testbench top: clock, reset, item stimulus, result back-pressure and verdict
`timescale 1ns / 100ps
module rv64i_instruction_execute_tb;
	import rvx_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   in_idle = 9;
	int   out_idle = 63;
	int   fails, pending;

	rvx_in_if  in_ch ();
	rvx_out_if out_ch ();

	rv64i_instruction_execute dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	rv64i_instruction_execute_chk chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.fails   (fails),
		.pending (pending)
	);

	always #5 clk = ~clk;

	initial begin
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
	end

	// result back-pressure
	always @(posedge clk)
		if (arst_n) out_ch.ready <= ($urandom_range(99) >= out_idle);

	function automatic logic [31:0] enc(input logic [6:0] f7, input logic [4:0] rs2,
		input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	// one transaction on the item channel, with random sender gaps
	task automatic send(input logic rt, input logic [31:0] ins, input logic [ADDR_W-1:0] la,
		input logic [7:0] lb);
		in_t t;
		if ($urandom_range(99) < in_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < in_idle) @(posedge clk);
		end
		t.req_type  = rt;
		t.instr     = ins;
		t.load_addr = la;
		t.load_byte = lb;
		in_ch.valid <= 1'b1;
		in_ch.data  <= t;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic exec(input logic [31:0] ins);
		send(REQ_EXEC, ins, ADDR_W'($urandom), 8'($urandom));
	endtask

	// addresses near either end of memory, or anywhere, so accesses overlap and wrap
	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [ADDR_W-1:0] x;
		x = ADDR_W'($urandom);
		case ($urandom_range(0, 2))
			0: return ADDR_W'(x[10:0]);
			1: return ADDR_W'(MEM_BYTES - 1 - x[10:0]);
			default: return x;
		endcase
	endfunction

	function automatic logic [31:0] rand_instr();
		logic [4:0]  rd, rs1, rs2;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [31:0] r;
		rd  = 5'($urandom);
		rs1 = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom);
		rs2 = 5'($urandom);
		f3  = 3'($urandom);
		f7  = 7'($urandom);
		r   = $urandom;
		case ($urandom_range(0, 19))
			0, 1, 2, 3: begin
				case ($urandom_range(0, 4))
					0, 1: f7 = 7'h00;
					2, 3: f7 = 7'h20;
					default: ;
				endcase
				return enc(f7, rs2, rs1, f3, rd, OP_R);
			end
			4, 5, 6, 7: begin
				if (f3 == 3'd1 || f3 == 3'd5) begin
					case ($urandom_range(0, 4))
						0, 1: f7 = {6'h00, f7[0]};
						2, 3: f7 = {6'h10, f7[0]};
						default: ;
					endcase
				end
				return enc(f7, rs2, rs1, f3, rd, OP_I);
			end
			8, 9, 10: begin
				rs1 = ($urandom_range(0, 1) == 0) ? 5'd0 : rs1;
				return enc(f7, rs2, rs1, f3, rd, OP_LOAD);
			end
			11, 12: begin
				rs1 = ($urandom_range(0, 1) == 0) ? 5'd0 : rs1;
				if ($urandom_range(0, 5) != 0) f3[2] = 1'b0;
				return enc(f7, rs2, rs1, f3, rd, OP_STORE);
			end
			13: return enc(f7, rs2, rs1, f3, rd, OP_BRANCH);
			14: return {r[31:12], rd, OP_LUI};
			15: return {r[31:12], rd, OP_AUIPC};
			16: return {r[31:12], rd, OP_JAL};
			17: begin
				if ($urandom_range(0, 3) != 0) f3 = 3'd0;
				return enc(f7, rs2, rs1, f3, rd, OP_JALR);
			end
			18: return r;
			default: return enc(f7, rs2, rs1, 3'd0, rd, OP_I);
		endcase
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and special cases
		send(REQ_PRELOAD, 32'hffff_ffff, '0, 8'hff);
		send(REQ_PRELOAD, 32'h0, ADDR_W'(MEM_BYTES - 1), 8'h80);
		send(REQ_PRELOAD, 32'h0, 17'h1ffff, 8'h7f);
		exec({20'h80000, 5'd1, OP_LUI});
		exec(enc(7'h7f, 5'h1f, 5'd0, 3'd0, 5'd2, OP_I));
		exec(enc(7'h3f, 5'h1f, 5'd0, 3'd0, 5'd3, OP_I));
		exec(enc(7'h00, 5'd2, 5'd1, 3'd0, 5'd4, OP_R));
		exec(enc(7'h20, 5'd2, 5'd1, 3'd0, 5'd5, OP_R));
		exec(enc(7'h00, 5'd3, 5'd2, 3'd1, 5'd6, OP_R));
		exec(enc(7'h00, 5'd2, 5'd1, 3'd2, 5'd7, OP_R));
		exec(enc(7'h00, 5'd2, 5'd1, 3'd3, 5'd8, OP_R));
		exec(enc(7'h00, 5'd3, 5'd2, 3'd5, 5'd9, OP_R));
		exec(enc(7'h20, 5'd3, 5'd1, 3'd5, 5'd10, OP_R));
		exec(enc(7'h01, 5'h1f, 5'd2, 3'd1, 5'd11, OP_I));
		exec(enc(7'h20, 5'd5, 5'd1, 3'd5, 5'd12, OP_I));
		exec(enc(7'h40, 5'd5, 5'd1, 3'd5, 5'd12, OP_I));
		exec(enc(7'h7f, 5'h1f, 5'd0, 3'd3, 5'd13, OP_I));
		exec(enc(7'h7f, 5'h1f, 5'd0, 3'd3, 5'd14, OP_LOAD));
		exec(enc(7'h7f, 5'h1f, 5'd0, 3'd0, 5'd15, OP_LOAD));
		exec(enc(7'h7f, 5'd2, 5'd0, 3'd3, 5'h1c, OP_STORE));
		exec(enc(7'h7f, 5'h1c, 5'd0, 3'd6, 5'd16, OP_LOAD));
		exec(enc(7'h7f, 5'd0, 5'd0, 3'd0, 5'h1f, OP_BRANCH));
		exec(enc(7'h00, 5'd2, 5'd1, 3'd2, 5'd8, OP_BRANCH));
		exec({20'hfffff, 5'd1, OP_JAL});
		exec(enc(7'h00, 5'd0, 5'd2, 3'd0, 5'd17, OP_JALR));
		exec(enc(7'h00, 5'd0, 5'd2, 3'd1, 5'd17, OP_JALR));
		exec({20'hfffff, 5'd18, OP_AUIPC});
		exec(enc(7'h00, 5'd2, 5'd2, 3'd0, 5'd0, OP_R));
		exec(32'h0000_0000);

		// random part in three idling phases
		for (int n = 0; n < 900; n++) begin
			if (n == 300) begin
				in_idle  = 63;
				out_idle = 9;
			end else if (n == 600) begin
				in_idle  = 0;
				out_idle = 0;
			end
			if ($urandom_range(0, 7) == 0)
				send(REQ_PRELOAD, $urandom, rand_addr(), 8'($urandom));
			else
				exec(rand_instr());
		end
		in_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("rv64i_instruction_execute_tb: clean");
		else
			$display("rv64i_instruction_execute_tb: errors");
		$finish;
	end

	// run limit
	initial begin
		#3ms;
		$display("rv64i_instruction_execute_tb: errors");
		$finish;
	end

endmodule

>>> rv64i_instruction_execute.f
rtl/rvx_pkg.sv
rtl/rvx_if.sv
rtl/rvx_regfile.sv
rtl/rvx_dmem.sv
rtl/rv64i_instruction_execute.sv
tb/rv64i_instruction_execute_chk.sv
tb/rv64i_instruction_execute_tb.sv
